>>> rtl/bbpg_pkg.sv
// Shared types, constants and the duty scale function of the buzzer burst generator.
`default_nettype none

package bbpg_pkg;

  localparam int COUNT_WIDTH_DEF = 17;

  localparam int REPEAT_W = 16;
  localparam int PERIOD_W = 17;
  localparam int DUTY_W   = 7;

  localparam logic [31:0] PERIOD_LIMIT = 32'd100000;
  localparam logic [31:0] PERCENT_FULL = 32'd100;

  // floor(x / 100) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^25
  localparam int          RECIP_SHIFT = 31;
  localparam logic [31:0] RECIP_MUL   = 32'd21474837;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ON    = 3'd2,
    PH_OFF   = 3'd3,
    PH_END   = 3'd4
  } phase_e;

  typedef struct packed {
    logic buzzer_level;
    logic busy;
  } seq_status_t;

  // Duty percent (already clamped to 100) times the reciprocal of 100.
  function automatic logic [31:0] duty_scale(input logic [DUTY_W-1:0] pct);
    logic [31:0] prod;
    prod = 32'(32'(pct) * RECIP_MUL);
    return prod;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bbpg_duty_calc.sv
// Clamps period and duty, splits the period into on and off lengths.
`default_nettype none

module bbpg_duty_calc #(
  parameter int COUNT_WIDTH = bbpg_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic [bbpg_pkg::PERIOD_W-1:0] period_ms_i,
  input  wire logic [bbpg_pkg::DUTY_W-1:0]   duty_percent_i,
  output logic      [COUNT_WIDTH-1:0]        on_len_o,
  output logic      [COUNT_WIDTH-1:0]        off_len_o
);

  localparam int PW = bbpg_pkg::PERIOD_W;
  localparam int MW = PW + 32;

  localparam logic [31:0] CountMask = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [PW-1:0] PerLimit =
    PW'((CountMask < bbpg_pkg::PERIOD_LIMIT) ? CountMask : bbpg_pkg::PERIOD_LIMIT);

  logic [PW-1:0]                  per_sat;
  logic [bbpg_pkg::DUTY_W-1:0]    pct_sat;
  logic [31:0]                    scale;
  logic [MW-1:0]                  prod;
  logic [PW-1:0]                  on_len;
  logic [PW-1:0]                  off_len;
  logic [31:0]                    on_ext;
  logic [31:0]                    off_ext;

  always_comb begin
    per_sat = (period_ms_i > PerLimit) ? PerLimit : period_ms_i;
    pct_sat = (duty_percent_i > bbpg_pkg::DUTY_W'(bbpg_pkg::PERCENT_FULL))
              ? bbpg_pkg::DUTY_W'(bbpg_pkg::PERCENT_FULL) : duty_percent_i;
    scale   = bbpg_pkg::duty_scale(pct_sat);
    prod    = MW'(per_sat) * MW'(scale);
    // quotient never exceeds the clamped period, so it fits the period width
    on_len  = prod[bbpg_pkg::RECIP_SHIFT +: PW];
    off_len = per_sat - on_len;
    on_ext  = 32'(on_len);
    off_ext = 32'(off_len);
  end

  assign on_len_o  = on_ext[COUNT_WIDTH-1:0];
  assign off_len_o = off_ext[COUNT_WIDTH-1:0];

endmodule

`default_nettype wire

>>> rtl/bbpg_sequencer.sv
// Five-phase burst sequencer with repeat and tick counters and the pin level.
`default_nettype none

module bbpg_sequencer #(
  parameter int COUNT_WIDTH = bbpg_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              step_i,
  input  wire logic                              op_i,
  input  wire logic [bbpg_pkg::REPEAT_W-1:0]     repeat_count_i,
  input  wire logic [COUNT_WIDTH-1:0]            on_len_i,
  input  wire logic [COUNT_WIDTH-1:0]            off_len_i,
  output bbpg_pkg::seq_status_t                  status_o
);

  localparam logic [COUNT_WIDTH-1:0] CntOne = COUNT_WIDTH'(1);

  bbpg_pkg::phase_e                  phase_q, phase_d;
  logic [bbpg_pkg::REPEAT_W-1:0]     repeats_q, repeats_d;
  logic [COUNT_WIDTH-1:0]            tick_cnt_q, tick_cnt_d;
  logic [COUNT_WIDTH-1:0]            on_len_q, on_len_d;
  logic [COUNT_WIDTH-1:0]            off_len_q, off_len_d;
  logic                              pin_q, pin_d;

  always_comb begin
    phase_d    = phase_q;
    repeats_d  = repeats_q;
    tick_cnt_d = tick_cnt_q;
    on_len_d   = on_len_q;
    off_len_d  = off_len_q;
    pin_d      = pin_q;
    if (step_i) begin
      if (op_i == bbpg_pkg::OP_START) begin
        // zero count leaves everything alone
        if (repeat_count_i != '0) begin
          repeats_d = repeat_count_i;
          on_len_d  = on_len_i;
          off_len_d = off_len_i;
          phase_d   = bbpg_pkg::PH_START;
        end
      end else begin
        case (phase_q)
          bbpg_pkg::PH_START: begin
            if (repeats_q != '0) begin
              repeats_d  = repeats_q - 16'd1;
              tick_cnt_d = on_len_q;
              phase_d    = bbpg_pkg::PH_ON;
            end else begin
              tick_cnt_d = '0;
              phase_d    = bbpg_pkg::PH_END;
            end
          end
          bbpg_pkg::PH_ON: begin
            if (tick_cnt_q != '0) begin
              tick_cnt_d = tick_cnt_q - CntOne;
              pin_d      = 1'b1;
            end else begin
              tick_cnt_d = off_len_q;
              phase_d    = bbpg_pkg::PH_OFF;
            end
          end
          bbpg_pkg::PH_OFF: begin
            if (tick_cnt_q != '0) begin
              tick_cnt_d = tick_cnt_q - CntOne;
              pin_d      = 1'b0;
            end else begin
              phase_d = bbpg_pkg::PH_START;
            end
          end
          bbpg_pkg::PH_END: begin
            pin_d   = 1'b0;
            phase_d = bbpg_pkg::PH_IDLE;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    status_o.buzzer_level = pin_q;
    status_o.busy         = (phase_q != bbpg_pkg::PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= bbpg_pkg::PH_IDLE;
      repeats_q  <= '0;
      tick_cnt_q <= '0;
      on_len_q   <= '0;
      off_len_q  <= '0;
      pin_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      repeats_q  <= repeats_d;
      tick_cnt_q <= tick_cnt_d;
      on_len_q   <= on_len_d;
      off_len_q  <= off_len_d;
      pin_q      <= pin_d;
    end
  end

  a_start_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && op_i == bbpg_pkg::OP_START && repeat_count_i != '0)
    |=> (phase_q == bbpg_pkg::PH_START && repeats_q == $past(repeat_count_i)))
    else $error("start request did not arm the sequencer");

  a_end_silences: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && op_i == bbpg_pkg::OP_TICK && phase_q == bbpg_pkg::PH_END)
    |=> (!pin_q && phase_q == bbpg_pkg::PH_IDLE))
    else $error("end phase left the buzzer on or did not go idle");

  a_hold_no_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> ($stable(phase_q) && $stable(pin_q) && $stable(tick_cnt_q)))
    else $error("sequencer state moved without a request");

  a_on_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && op_i == bbpg_pkg::OP_TICK && phase_q == bbpg_pkg::PH_ON && tick_cnt_q != '0)
    |=> (pin_q && tick_cnt_q == $past(tick_cnt_q) - CntOne))
    else $error("on phase tick did not sound and count down");

endmodule

`default_nettype wire

>>> rtl/buzzer_burst_pulse_generator_top.sv
// Top level of the buzzer burst generator: request register, duty split, sequencer.
`default_nettype none

// Takes one request per clock (tick or start) while in_stall_o is low, and returns one
// result per request with the pin level and busy flag after that request. A request
// is first held in the input register; when the result slot is empty or being taken,
// the duty split (one 17x32 multiply by the reciprocal of 100) and the phase update
// run from that register into the sequencer state registers, which are the result.
// While a result is stalled one more request is held in the input register.
module buzzer_burst_pulse_generator_top #(
  parameter int COUNT_WIDTH = bbpg_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           op_i,
  input  wire logic [bbpg_pkg::REPEAT_W-1:0]  repeat_count_i,
  input  wire logic [bbpg_pkg::PERIOD_W-1:0]  period_ms_i,
  input  wire logic [bbpg_pkg::DUTY_W-1:0]    duty_percent_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                buzzer_level_o,
  output logic                                busy_res_o
);

  logic                           in_valid_q, in_valid_d;
  logic                           out_valid_q, out_valid_d;
  logic                           op_q;
  logic [bbpg_pkg::REPEAT_W-1:0]  repeat_q;
  logic [bbpg_pkg::PERIOD_W-1:0]  period_q;
  logic [bbpg_pkg::DUTY_W-1:0]    duty_q;
  logic                           accept;
  logic                           advance;
  logic [COUNT_WIDTH-1:0]         on_len;
  logic [COUNT_WIDTH-1:0]         off_len;
  bbpg_pkg::seq_status_t          status;

  // held request moves on when the result slot is empty or being taken
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_i;
      repeat_q <= repeat_count_i;
      period_q <= period_ms_i;
      duty_q   <= duty_percent_i;
    end
  end

  bbpg_duty_calc #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_duty_calc (
    .period_ms_i    (period_q),
    .duty_percent_i (duty_q),
    .on_len_o       (on_len),
    .off_len_o      (off_len)
  );

  bbpg_sequencer #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_sequencer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .op_i           (op_q),
    .repeat_count_i (repeat_q),
    .on_len_i       (on_len),
    .off_len_i      (off_len),
    .status_o       (status)
  );

  assign out_valid_o    = out_valid_q;
  assign buzzer_level_o = status.buzzer_level;
  assign busy_res_o     = status.busy;

endmodule

`default_nettype wire

>>> dv/bbpg_status_checker.sv
// Status checker: tracks the burst sequencer per request and compares each result.
`timescale 1ns / 100ps

module bbpg_status_checker #(
  parameter int COUNT_WIDTH = bbpg_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire logic                          op_i,
  input  wire logic [bbpg_pkg::REPEAT_W-1:0] repeat_count_i,
  input  wire logic [bbpg_pkg::PERIOD_W-1:0] period_ms_i,
  input  wire logic [bbpg_pkg::DUTY_W-1:0]   duty_percent_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire logic                          buzzer_level_i,
  input  wire logic                          busy_res_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o
);

  localparam logic [31:0] CountMask = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
  localparam logic [31:0] PeriodCap = (CountMask < bbpg_pkg::PERIOD_LIMIT)
                                      ? CountMask : bbpg_pkg::PERIOD_LIMIT;
  localparam int          MaxReports = 10;

  bbpg_pkg::phase_e                 phase_q;
  logic [bbpg_pkg::REPEAT_W-1:0]    beeps_left_q;
  logic [COUNT_WIDTH-1:0]           tick_cnt_q;
  logic [COUNT_WIDTH-1:0]           on_ticks_q;
  logic [COUNT_WIDTH-1:0]           off_ticks_q;
  logic                             pin_q;

  bbpg_pkg::seq_status_t expected_status_q[$];
  int                    fail_cnt;
  int                    result_cnt;

  task automatic advance_sequencer(input logic                          op,
                                   input logic [bbpg_pkg::REPEAT_W-1:0] cnt,
                                   input logic [bbpg_pkg::PERIOD_W-1:0] per,
                                   input logic [bbpg_pkg::DUTY_W-1:0]   pct);
    logic [31:0] per_sat;
    logic [31:0] pct_sat;
    logic [31:0] on_ticks;
    if (op == bbpg_pkg::OP_START) begin
      // zero count leaves everything as it was
      if (cnt != '0) begin
        per_sat      = (32'(per) > PeriodCap) ? PeriodCap : 32'(per);
        pct_sat      = (32'(pct) > bbpg_pkg::PERCENT_FULL) ? bbpg_pkg::PERCENT_FULL
                                                           : 32'(pct);
        on_ticks     = (per_sat * pct_sat) / bbpg_pkg::PERCENT_FULL;
        beeps_left_q = cnt;
        on_ticks_q   = COUNT_WIDTH'(on_ticks);
        off_ticks_q  = COUNT_WIDTH'(per_sat - on_ticks);
        phase_q      = bbpg_pkg::PH_START;
      end
    end else begin
      case (phase_q)
        bbpg_pkg::PH_START: begin
          if (beeps_left_q != '0) begin
            beeps_left_q = beeps_left_q - bbpg_pkg::REPEAT_W'(1);
            tick_cnt_q   = on_ticks_q;
            phase_q      = bbpg_pkg::PH_ON;
          end else begin
            tick_cnt_q = '0;
            phase_q    = bbpg_pkg::PH_END;
          end
        end
        bbpg_pkg::PH_ON: begin
          if (tick_cnt_q != '0) begin
            tick_cnt_q = tick_cnt_q - COUNT_WIDTH'(1);
            pin_q      = 1'b1;
          end else begin
            tick_cnt_q = off_ticks_q;
            phase_q    = bbpg_pkg::PH_OFF;
          end
        end
        bbpg_pkg::PH_OFF: begin
          if (tick_cnt_q != '0) begin
            tick_cnt_q = tick_cnt_q - COUNT_WIDTH'(1);
            pin_q      = 1'b0;
          end else begin
            phase_q = bbpg_pkg::PH_START;
          end
        end
        bbpg_pkg::PH_END: begin
          pin_q   = 1'b0;
          phase_q = bbpg_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
  endtask

  task automatic flag_mismatch(input string field, input logic want, input logic got);
    fail_cnt++;
    if (fail_cnt <= MaxReports)
      $display("%0t: result %0d %s mismatch: expected %0b, got %0b",
               $realtime, result_cnt, field, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    bbpg_pkg::seq_status_t want;
    if (!rst_ni) begin
      phase_q      = bbpg_pkg::PH_IDLE;
      beeps_left_q = '0;
      tick_cnt_q   = '0;
      on_ticks_q   = '0;
      off_ticks_q  = '0;
      pin_q        = 1'b0;
      expected_status_q.delete();
      fail_cnt     = 0;
      result_cnt   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        advance_sequencer(op_i, repeat_count_i, period_ms_i, duty_percent_i);
        want.buzzer_level = pin_q;
        want.busy         = (phase_q != bbpg_pkg::PH_IDLE);
        expected_status_q.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_status_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports)
            $display("%0t: result with no request pending: level %0b busy %0b",
                     $realtime, buzzer_level_i, busy_res_i);
        end else begin
          want = expected_status_q.pop_front();
          if (buzzer_level_i !== want.buzzer_level)
            flag_mismatch("buzzer_level", want.buzzer_level, buzzer_level_i);
          if (busy_res_i !== want.busy)
            flag_mismatch("busy_res", want.busy, busy_res_i);
        end
        result_cnt++;
      end
      fail_count_o <= fail_cnt;
      pending_o    <= expected_status_q.size();
      checked_o    <= result_cnt;
    end
  end

endmodule

>>> dv/testbench.sv
// Testbench top: clock, reset, request and stall generation, and the final verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int  ClkPeriod   = 10;
  localparam int  ResetCycles = 6;
  localparam int  RandomItems = 450;
  localparam int  IdlePct     = 23;
  localparam int  LongHold    = 40;
  localparam int  DrainCycles = 10;
  localparam time TimeoutNs   = 2_000_000;

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          in_valid_i     = 1'b0;
  logic                          op_i           = bbpg_pkg::OP_TICK;
  logic [bbpg_pkg::REPEAT_W-1:0] repeat_count_i = '0;
  logic [bbpg_pkg::PERIOD_W-1:0] period_ms_i    = '0;
  logic [bbpg_pkg::DUTY_W-1:0]   duty_percent_i = '0;
  logic                          out_stall_i    = 1'b0;
  logic                          in_stall_o;
  logic                          out_valid_o;
  logic                          buzzer_level_o;
  logic                          busy_res_o;

  int   fail_count;
  int   pending;
  int   checked;
  int   counted_items = 0;
  int   start_cnt     = 0;
  int   tick_cnt      = 0;
  int   long_holds    = 0;
  bit   idle_en       = 1'b1;

  buzzer_burst_pulse_generator_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .repeat_count_i (repeat_count_i),
    .period_ms_i    (period_ms_i),
    .duty_percent_i (duty_percent_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .buzzer_level_o (buzzer_level_o),
    .busy_res_o     (busy_res_o)
  );

  bbpg_status_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .op_i           (op_i),
    .repeat_count_i (repeat_count_i),
    .period_ms_i    (period_ms_i),
    .duty_percent_i (duty_percent_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .buzzer_level_i (buzzer_level_o),
    .busy_res_i     (busy_res_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Called right after a falling edge; returns right after the next falling edge
  // following acceptance, so back-to-back requests keep valid high.
  task automatic send_request(input logic                          op,
                              input logic [bbpg_pkg::REPEAT_W-1:0] cnt,
                              input logic [bbpg_pkg::PERIOD_W-1:0] per,
                              input logic [bbpg_pkg::DUTY_W-1:0]   pct);
    while (idle_en && ($urandom_range(99) < IdlePct)) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    op_i           = op;
    repeat_count_i = cnt;
    period_ms_i    = per;
    duty_percent_i = pct;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    if (op == bbpg_pkg::OP_START) start_cnt++;
    else tick_cnt++;
    if (!(op == bbpg_pkg::OP_START && cnt == '0)) counted_items++;
  endtask

  // tick fields are not read by the block; keep them toggling anyway
  task automatic send_ticks(input int n);
    repeat (n) send_request(bbpg_pkg::OP_TICK, bbpg_pkg::REPEAT_W'($urandom),
                            bbpg_pkg::PERIOD_W'($urandom), bbpg_pkg::DUTY_W'($urandom));
  endtask

  // Short burst with random content; sometimes cut short so the next start lands mid-burst.
  task automatic burst_sequence();
    logic [bbpg_pkg::REPEAT_W-1:0] cnt;
    logic [bbpg_pkg::PERIOD_W-1:0] per;
    logic [bbpg_pkg::DUTY_W-1:0]   pct;
    int                            full_len;
    cnt      = bbpg_pkg::REPEAT_W'($urandom_range(3, 1));
    per      = bbpg_pkg::PERIOD_W'($urandom_range(10, 0));
    pct      = bbpg_pkg::DUTY_W'($urandom_range(127, 0));
    full_len = int'(cnt) * (int'(per) + 3) + 2;
    send_request(bbpg_pkg::OP_START, cnt, per, pct);
    if ($urandom_range(3) == 0) send_ticks($urandom_range(full_len, 0));
    else send_ticks(full_len + $urandom_range(2, 0));
  endtask

  // receiver: random stalls plus two long hold-offs to back up the pipeline
  initial begin : out_side
    int cyc;
    int hold_left;
    cyc       = 0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc == 150 || cyc == 900) begin
        hold_left = LongHold;
        long_holds++;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = idle_en && ($urandom_range(99) < IdlePct);
      end
    end
  end

  initial begin : stimulus
    int kind;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: idle tick, ignored start, a plain burst, saturated fields,
    // restart while busy with full duty (end phase must silence the pin)
    send_ticks(1);
    send_request(bbpg_pkg::OP_START, '0, '1, '1);
    send_request(bbpg_pkg::OP_START, bbpg_pkg::REPEAT_W'(1), bbpg_pkg::PERIOD_W'(4),
                 bbpg_pkg::DUTY_W'(50));
    send_ticks(9);
    send_request(bbpg_pkg::OP_START, '1, '1, '1);
    send_ticks(3);
    send_request(bbpg_pkg::OP_START, bbpg_pkg::REPEAT_W'(1), bbpg_pkg::PERIOD_W'(2),
                 bbpg_pkg::DUTY_W'(100));
    send_ticks(8);

    counted_items = 0;
    while (counted_items < RandomItems) begin
      idle_en = !(counted_items >= 200 && counted_items < 300);
      kind = $urandom_range(15);
      if (kind < 11) begin
        burst_sequence();
      end else if (kind < 13) begin
        send_request(bbpg_pkg::OP_START, bbpg_pkg::REPEAT_W'($urandom),
                     bbpg_pkg::PERIOD_W'($urandom), bbpg_pkg::DUTY_W'($urandom));
        send_ticks($urandom_range(4, 0));
      end else if (kind < 15) begin
        send_ticks($urandom_range(5, 1));
      end else begin
        send_request(bbpg_pkg::OP_START, '0, bbpg_pkg::PERIOD_W'($urandom),
                     bbpg_pkg::DUTY_W'($urandom));
      end
    end
    in_valid_i = 1'b0;
    idle_en    = 1'b1;

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run: %0d requests (%0d starts, %0d ticks), %0d results compared.",
             start_cnt + tick_cnt, start_cnt, tick_cnt, checked);
    $display("Output held off for %0d long stretches; %0d mismatches seen.",
             long_holds, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("Timeout with %0d results outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bbpg_pkg.sv
rtl/bbpg_duty_calc.sv
rtl/bbpg_sequencer.sv
rtl/buzzer_burst_pulse_generator_top.sv
dv/bbpg_status_checker.sv
dv/testbench.sv
